[src/stereo_modulated_delay_filter_top_defines.svh]
// Assertion macros for the modulated delay filter checker
`ifndef STEREO_MODULATED_DELAY_FILTER_TOP_DEFINES_SVH
`define STEREO_MODULATED_DELAY_FILTER_TOP_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define SMDF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error("smdf assertion failed");

// consequent sequence starts in the antecedent cycle
`define SMDF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("smdf assertion failed");

`endif

[src/smdf_pkg.sv]
// Shared types, constants and saturation helper for the modulated delay filter
`timescale 1ns / 1ps
package smdf_pkg;

   localparam int SAMPLE_BITS   = 24;
   localparam int FRAC_BITS     = 12;
   localparam int DELAY_BITS    = 22;
   localparam int AMOUNT_BITS   = 17;
   localparam int COEF_BITS     = 24;
   localparam int STATE_BITS    = 32;
   localparam int ACC_BITS      = SAMPLE_BITS + 6;
   localparam int CSR_IDX_BITS  = 3;
   localparam int DEF_BUF_DEPTH = 1024;
   localparam int AMOUNT_FULL   = 65536;
   localparam int DELAY_MIN     = 4096;
   localparam int COEF_ONE      = 16777216;

   localparam logic [COEF_BITS-1:0] LP_ZERO_RST = 24'd1223000;
   localparam logic [COEF_BITS-1:0] LP_FULL_RST = 24'd11328000;
   localparam logic [COEF_BITS-1:0] HP_ZERO_RST = 24'd16733340;
   localparam logic [COEF_BITS-1:0] HP_FULL_RST = 24'd16559024;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_LP_ZERO = 3'd0,
      CSR_LP_FULL = 3'd1,
      CSR_HP_ZERO = 3'd2,
      CSR_HP_FULL = 3'd3
   } csr_index_type;

   typedef logic [3:0][SAMPLE_BITS-1:0] taps_type;

   typedef struct packed {
      logic [COEF_BITS-1:0] lp_zero;
      logic [COEF_BITS-1:0] lp_full;
      logic [COEF_BITS-1:0] hp_zero;
      logic [COEF_BITS-1:0] hp_full;
   } coef_type;

   typedef struct packed {
      logic start;
      logic bypass_load;
      logic ch;
   } filt_ctrl_type;

   function automatic logic signed [STATE_BITS-1:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[STATE_BITS-1:0];
   endfunction

endpackage

[src/smdf_ifs.sv]
// Word channel interfaces: input, result and register write
`timescale 1ns / 1ps
interface smdf_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   channel_in;
   logic signed [smdf_pkg::SAMPLE_BITS-1:0] sample_in;
   logic [smdf_pkg::DELAY_BITS-1:0]        read_delay;
   logic [smdf_pkg::AMOUNT_BITS-1:0]       amount;
   logic                                   bypass;
   modport source (output valid, channel_in, sample_in, read_delay, amount, bypass,
                   input ready);
   modport sink (input valid, channel_in, sample_in, read_delay, amount, bypass,
                 output ready);
endinterface

interface smdf_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   channel_out;
   logic signed [smdf_pkg::SAMPLE_BITS-1:0] sample_out;
   modport source (output valid, channel_out, sample_out, input ready);
   modport sink (input valid, channel_out, sample_out, output ready);
endinterface

interface smdf_csr_if;
   logic                              valid;
   logic                              ready;
   logic [smdf_pkg::CSR_IDX_BITS-1:0] index;
   logic [smdf_pkg::COEF_BITS-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[src/smdf_store.sv]
// Stereo delay sample store: one write port, one registered read port
`timescale 1ns / 1ps
module smdf_store #(
   parameter int ADDR_BITS = $clog2(smdf_pkg::DEF_BUF_DEPTH) + 1
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [ADDR_BITS-1:0]             waddr,
   input  logic [smdf_pkg::SAMPLE_BITS-1:0] wdata,
   input  logic                             re,
   input  logic [ADDR_BITS-1:0]             raddr,
   output logic [smdf_pkg::SAMPLE_BITS-1:0] rdata
);

   logic [smdf_pkg::SAMPLE_BITS-1:0] mem [2**ADDR_BITS];
   logic [smdf_pkg::SAMPLE_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/smdf_interp.sv]
// Cubic Hermite evaluator: three multiply-accumulate steps on the fraction
`timescale 1ns / 1ps
module smdf_interp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  smdf_pkg::taps_type                     taps,
   input  logic [smdf_pkg::FRAC_BITS-1:0]         frac,
   output logic signed [smdf_pkg::STATE_BITS-1:0] value,
   output logic                                   done
);

   localparam int AW = smdf_pkg::ACC_BITS;
   localparam int FB = smdf_pkg::FRAC_BITS;

   typedef enum logic [1:0] {I_IDLE, I_STEP, I_FIN} istate_type;

   istate_type              state_ff;
   logic [1:0]              step_ff;
   logic signed [AW-1:0]    acc_ff;
   logic signed [smdf_pkg::STATE_BITS-1:0] value_ff;
   logic                    done_ff;

   logic signed [AW-1:0]    y0, y1, y2, y3;
   logic signed [AW-1:0]    d1, d2, d3, two_y1, addend;
   logic signed [AW+FB:0]   prod;
   logic signed [AW-1:0]    acc_in;
   logic signed [AW:0]      half;
   logic signed [smdf_pkg::STATE_BITS-1:0] value_in;

   always_comb begin
      y0     = AW'($signed(taps[0]));
      y1     = AW'($signed(taps[1]));
      y2     = AW'($signed(taps[2]));
      y3     = AW'($signed(taps[3]));
      d1     = y2 - y0;
      d2     = (y0 <<< 1) - (y1 <<< 2) - y1 + (y2 <<< 2) - y3;
      d3     = y3 - y0 + (y1 - y2) + ((y1 - y2) <<< 1);
      two_y1 = y1 <<< 1;
      case (step_ff)
         2'd0:    addend = d2;
         2'd1:    addend = d1;
         default: addend = two_y1;
      endcase
      prod     = acc_ff * $signed({1'b0, frac});
      acc_in   = AW'(prod >>> FB) + addend;
      half     = ((AW + 1)'(acc_ff) + (AW + 1)'(1)) >>> 1;
      value_in = smdf_pkg::sat32(64'(half) <<< 6);
   end

   always_ff @(posedge clock) begin
      done_ff <= !reset && (state_ff == I_FIN);
      if (reset) begin
         state_ff <= I_IDLE;
         step_ff  <= 2'd0;
      end else begin
         unique case (state_ff)
            I_IDLE: begin
               if (start) begin
                  acc_ff   <= d3;
                  step_ff  <= 2'd0;
                  state_ff <= I_STEP;
               end
            end
            I_STEP: begin
               acc_ff  <= acc_in;
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd2) begin
                  state_ff <= I_FIN;
               end
            end
            I_FIN: begin
               value_ff <= value_in;
               state_ff <= I_IDLE;
            end
            default: state_ff <= I_IDLE;
         endcase
      end
   end

   assign value = value_ff;
   assign done  = done_ff;

endmodule

[src/smdf_filter.sv]
// Coefficient blend, high-pass and low-pass pole updates with per-channel state
`timescale 1ns / 1ps
module smdf_filter (
   input  logic                                    clock,
   input  logic                                    reset,
   input  smdf_pkg::filt_ctrl_type                 ctrl,
   input  smdf_pkg::coef_type                      coef,
   input  logic [smdf_pkg::AMOUNT_BITS-1:0]        amount,
   input  logic signed [smdf_pkg::STATE_BITS-1:0]  value,
   input  logic signed [smdf_pkg::SAMPLE_BITS-1:0] sample,
   output logic signed [smdf_pkg::SAMPLE_BITS-1:0] result,
   output logic                                    done
);

   localparam int SW = smdf_pkg::SAMPLE_BITS;
   localparam int TW = smdf_pkg::STATE_BITS;
   localparam int CB = smdf_pkg::COEF_BITS;
   localparam logic signed [TW+1:0] SMAX = (TW + 2)'(2 ** (SW - 1) - 1);
   localparam logic signed [TW+1:0] SMIN = -(TW + 2)'(2 ** (SW - 1));

   typedef enum logic [2:0] {F_IDLE, F_BLEND, F_HP, F_HPO, F_LP, F_OUT} fstate_type;

   fstate_type            state_ff;
   logic                  ch_ff;
   logic [CB-1:0]         ahp_ff, alp_ff;
   logic signed [TW-1:0]  hp_ff [2];
   logic signed [TW-1:0]  lp_ff [2];
   logic signed [TW-1:0]  hpn_ff, hpo_ff, lpn_ff;
   logic signed [SW-1:0]  result_ff;
   logic                  done_ff;

   logic [CB-1:0]         ahp_in, alp_in;
   logic signed [TW-1:0]  hpn_in, hpo_in, lpn_in, lpb_in;
   logic signed [TW+1:0]  rnd;
   logic signed [SW-1:0]  result_in;

   function automatic logic [CB-1:0] blend(input logic [CB-1:0] c0, input logic [CB-1:0] c1,
                                           input logic [smdf_pkg::AMOUNT_BITS-1:0] amt);
      logic signed [CB:0]   d;
      logic signed [CB+18:0] p;
      logic signed [CB+1:0] s;
      d = $signed({1'b0, c1}) - $signed({1'b0, c0});
      p = d * $signed({1'b0, amt});
      s = (CB + 2)'($signed({1'b0, c0})) + (CB + 2)'(p >>> 16);
      return s[CB-1:0];
   endfunction

   function automatic logic signed [TW-1:0] pole(input logic signed [TW-1:0] s,
                                                 input logic signed [TW-1:0] x,
                                                 input logic [CB-1:0] a);
      logic signed [TW:0]      diff;
      logic signed [CB+1:0]    k;
      logic signed [TW+CB+2:0] p;
      logic signed [TW+3:0]    sum;
      diff = (TW + 1)'(x) - (TW + 1)'(s);
      k    = $signed((CB + 2)'(smdf_pkg::COEF_ONE) - (CB + 2)'(a));
      p    = diff * k;
      sum  = (TW + 4)'(s) + (TW + 4)'(p >>> CB);
      return smdf_pkg::sat32(64'(sum));
   endfunction

   always_comb begin
      ahp_in = blend(coef.hp_zero, coef.hp_full, amount);
      alp_in = blend(coef.lp_zero, coef.lp_full, amount);
      hpn_in = pole(hp_ff[ch_ff], value, ahp_ff);
      hpo_in = smdf_pkg::sat32(64'(value) - 64'(hpn_ff));
      lpn_in = pole(lp_ff[ch_ff], hpo_ff, alp_ff);
      lpb_in = TW'(sample) <<< 6;
      rnd    = ((TW + 2)'(lpn_ff) + (TW + 2)'(32)) >>> 6;
      if (rnd > SMAX) begin
         result_in = SMAX[SW-1:0];
      end else if (rnd < SMIN) begin
         result_in = SMIN[SW-1:0];
      end else begin
         result_in = rnd[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      done_ff <= !reset && (state_ff == F_OUT);
      if (reset) begin
         state_ff <= F_IDLE;
         hp_ff[0] <= '0;
         hp_ff[1] <= '0;
         lp_ff[0] <= '0;
         lp_ff[1] <= '0;
      end else begin
         if (ctrl.bypass_load) begin
            lp_ff[ctrl.ch] <= lpb_in;
         end
         unique case (state_ff)
            F_IDLE: begin
               if (ctrl.start) begin
                  ch_ff    <= ctrl.ch;
                  state_ff <= F_BLEND;
               end
            end
            F_BLEND: begin
               ahp_ff   <= ahp_in;
               alp_ff   <= alp_in;
               state_ff <= F_HP;
            end
            F_HP: begin
               hpn_ff        <= hpn_in;
               hp_ff[ch_ff]  <= hpn_in;
               state_ff      <= F_HPO;
            end
            F_HPO: begin
               hpo_ff   <= hpo_in;
               state_ff <= F_LP;
            end
            F_LP: begin
               lpn_ff       <= lpn_in;
               lp_ff[ch_ff] <= lpn_in;
               state_ff     <= F_OUT;
            end
            F_OUT: begin
               result_ff <= result_in;
               state_ff  <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign result = result_ff;
   assign done   = done_ff;

endmodule

[src/stereo_modulated_delay_filter_top.sv]
// Filtered word: position, address, read, Hermite and filter states, then the output register;
// the next word can be taken in the cycle the result first shows valid. Bypass: S_OUT loads
// the sample into the output register. Words go one at a time; a stalled output holds S_OUT.
// Four store reads on one read port, three Hermite and three filter multiply steps run in turn.
// Reset is synchronous; no clearing pass: per-channel fill tracking reads unwritten
// store entries as zero, filter states and write positions clear at once.
`timescale 1ns / 1ps
module stereo_modulated_delay_filter_top #(
   parameter int BUF_DEPTH = smdf_pkg::DEF_BUF_DEPTH
) (
   input logic         clock,
   input logic         reset,
   smdf_req_if.sink    req_chan,
   smdf_rsp_if.source  rsp_chan,
   smdf_csr_if.sink    csr_chan
);

   localparam int AW = $clog2(BUF_DEPTH);
   localparam int FB = smdf_pkg::FRAC_BITS;
   localparam int PW = AW + FB;
   localparam int CW = (PW > smdf_pkg::DELAY_BITS) ? PW : smdf_pkg::DELAY_BITS;
   localparam int SW = smdf_pkg::SAMPLE_BITS;
   localparam int MB = smdf_pkg::AMOUNT_BITS;
   localparam logic [CW-1:0] DLY_MIN = CW'(smdf_pkg::DELAY_MIN);
   localparam logic [CW-1:0] DLY_MAX = CW'((BUF_DEPTH - 3) * (2 ** FB));
   localparam logic [PW:0]   SPAN    = (PW + 1)'(BUF_DEPTH * (2 ** FB));
   localparam logic [AW-1:0] LAST    = AW'(BUF_DEPTH - 1);
   localparam logic [MB-1:0] AMT_MAX = MB'(smdf_pkg::AMOUNT_FULL);
   localparam logic [2:0]    RD_LAST = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE, S_POS, S_ADDR, S_READ, S_INTERP, S_FILTER, S_OUT
   } state_type;

   state_type             state_ff;
   logic [AW-1:0]         wp_ff [2];
   logic                  wrap_ff [2];
   logic                  ch_ff;
   logic [PW-1:0]         dly_ff;
   logic [MB-1:0]         amt_ff;
   logic [AW-1:0]         wp_q_ff;
   logic                  wrap_q_ff;
   logic [PW-1:0]         pos_ff;
   logic [AW-1:0]         rd_idx_ff;
   logic [FB-1:0]         frac_ff;
   logic [2:0]            rd_cnt_ff;
   logic                  vld_ff;
   smdf_pkg::taps_type    taps_ff;
   logic                  istart_ff;
   logic                  fstart_ff;
   logic signed [SW-1:0]  res_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_ch_ff;
   logic signed [SW-1:0]  rsp_smp_ff;
   smdf_pkg::coef_type    coef_ff;

   logic                  accept;
   logic                  rsp_load;
   logic [CW-1:0]         dly_ext, dly_clamp;
   logic [MB-1:0]         amt_in;
   logic [PW:0]           diff;
   logic [PW-1:0]         pos_in;
   logic [AW-1:0]         i1, first_idx, next_idx, wp_cur, wp_in;
   logic [1:0]            tap_sel;
   logic                  re;
   logic [SW-1:0]         rdata;
   logic signed [smdf_pkg::STATE_BITS-1:0] ivalue;
   logic                  idone, fdone;
   logic signed [SW-1:0]  fresult;
   smdf_pkg::filt_ctrl_type fctrl;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      dly_ext = CW'(req_chan.read_delay);
      if (dly_ext < DLY_MIN) begin
         dly_clamp = DLY_MIN;
      end else if (dly_ext > DLY_MAX) begin
         dly_clamp = DLY_MAX;
      end else begin
         dly_clamp = dly_ext;
      end
      amt_in    = (req_chan.amount > AMT_MAX) ? AMT_MAX : req_chan.amount;
      wp_cur    = wp_ff[req_chan.channel_in];
      wp_in     = (wp_cur == LAST) ? '0 : wp_cur + AW'(1);
      diff      = {1'b0, wp_q_ff, {FB{1'b0}}} - {1'b0, dly_ff};
      pos_in    = diff[PW] ? PW'(diff + SPAN) : diff[PW-1:0];
      i1        = pos_ff[PW-1:FB];
      first_idx = (i1 == '0) ? LAST : i1 - AW'(1);
      next_idx  = (rd_idx_ff == LAST) ? '0 : rd_idx_ff + AW'(1);
      tap_sel   = 2'(rd_cnt_ff - 3'd1);
      re        = (state_ff == S_READ) && (rd_cnt_ff != RD_LAST);
      fctrl.start       = fstart_ff;
      fctrl.bypass_load = accept && req_chan.bypass;
      fctrl.ch          = fctrl.bypass_load ? req_chan.channel_in : ch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.lp_zero <= smdf_pkg::LP_ZERO_RST;
         coef_ff.lp_full <= smdf_pkg::LP_FULL_RST;
         coef_ff.hp_zero <= smdf_pkg::HP_ZERO_RST;
         coef_ff.hp_full <= smdf_pkg::HP_FULL_RST;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            smdf_pkg::CSR_LP_ZERO: coef_ff.lp_zero <= csr_chan.data;
            smdf_pkg::CSR_LP_FULL: coef_ff.lp_full <= csr_chan.data;
            smdf_pkg::CSR_HP_ZERO: coef_ff.hp_zero <= csr_chan.data;
            smdf_pkg::CSR_HP_FULL: coef_ff.hp_full <= csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      istart_ff <= !reset && (state_ff == S_READ) && (rd_cnt_ff == RD_LAST);
      fstart_ff <= !reset && (state_ff == S_INTERP) && idone;
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff[0]     <= '0;
         wp_ff[1]     <= '0;
         wrap_ff[0]   <= 1'b0;
         wrap_ff[1]   <= 1'b0;
         rd_cnt_ff    <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  ch_ff     <= req_chan.channel_in;
                  dly_ff    <= dly_clamp[PW-1:0];
                  amt_ff    <= amt_in;
                  wp_q_ff   <= wp_cur;
                  wrap_q_ff <= wrap_ff[req_chan.channel_in];
                  res_ff    <= req_chan.sample_in;
                  wp_ff[req_chan.channel_in] <= wp_in;
                  if (wp_cur == LAST) begin
                     wrap_ff[req_chan.channel_in] <= 1'b1;
                  end
                  state_ff <= req_chan.bypass ? S_OUT : S_POS;
               end
            end
            S_POS: begin
               pos_ff   <= pos_in;
               state_ff <= S_ADDR;
            end
            S_ADDR: begin
               rd_idx_ff <= first_idx;
               frac_ff   <= pos_ff[FB-1:0];
               rd_cnt_ff <= 3'd0;
               state_ff  <= S_READ;
            end
            S_READ: begin
               if (rd_cnt_ff != RD_LAST) begin
                  rd_idx_ff <= next_idx;
                  vld_ff    <= wrap_q_ff || (rd_idx_ff <= wp_q_ff);
               end
               if (rd_cnt_ff != 3'd0) begin
                  taps_ff[tap_sel] <= vld_ff ? rdata : '0;
               end
               rd_cnt_ff <= rd_cnt_ff + 3'd1;
               if (rd_cnt_ff == RD_LAST) begin
                  state_ff <= S_INTERP;
               end
            end
            S_INTERP: begin
               if (idone) begin
                  state_ff <= S_FILTER;
               end
            end
            S_FILTER: begin
               if (fdone) begin
                  res_ff   <= fresult;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_load) begin
                  rsp_ch_ff    <= ch_ff;
                  rsp_smp_ff   <= res_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.channel_out = rsp_ch_ff;
   assign rsp_chan.sample_out  = rsp_smp_ff;

   smdf_store #(
      .ADDR_BITS (AW + 1)
   ) u_store (
      .clock (clock),
      .we    (accept),
      .waddr ({req_chan.channel_in, wp_cur}),
      .wdata (req_chan.sample_in),
      .re    (re),
      .raddr ({ch_ff, rd_idx_ff}),
      .rdata (rdata)
   );

   smdf_interp u_interp (
      .clock (clock),
      .reset (reset),
      .start (istart_ff),
      .taps  (taps_ff),
      .frac  (frac_ff),
      .value (ivalue),
      .done  (idone)
   );

   smdf_filter u_filter (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (fctrl),
      .coef   (coef_ff),
      .amount (amt_ff),
      .value  (ivalue),
      .sample (req_chan.sample_in),
      .result (fresult),
      .done   (fdone)
   );

endmodule

[src/smdf_checker.sv]
// Port-level checker for the modulated delay filter, bound to the top level
`timescale 1ns / 1ps
`include "stereo_modulated_delay_filter_top_defines.svh"
module smdf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             req_bypass,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_channel,
   input logic [smdf_pkg::SAMPLE_BITS-1:0] rsp_sample
);

   `SMDF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SMDF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_sample) && $stable(rsp_channel))
   `SMDF_ASSERT_NEXT(a_one_word, clock, reset, req_valid && req_ready, !req_ready)
   `SMDF_ASSERT_SAME(a_bypass_lat, clock, reset, req_valid && req_ready && req_bypass && !rsp_valid, ##2 rsp_valid)

endmodule

bind stereo_modulated_delay_filter_top smdf_checker u_smdf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_bypass  (req_chan.bypass),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_channel (rsp_chan.channel_out),
   .rsp_sample  (rsp_chan.sample_out)
);
